[rtl/rational_arithmetic_unit_core_macros.svh]
// assertion macros shared by the rational arithmetic unit rtl
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RAU_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rau: implication check failed");

// next-cycle implication, disabled while reset is asserted
`define RAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rau: next-cycle check failed");

`endif

[rtl/rau_pkg.sv]
// package with widths, codes and types of the rational arithmetic unit
package rau_pkg;

  localparam int FIELD_W   = 32;
  localparam int WORD_BITS = 32;
  localparam int MAG_W     = FIELD_W;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int CNT_W     = $clog2(PROD_W);
  localparam int RES_DEN_W = FIELD_W - 1;

  localparam logic [PROD_W-1:0] LIMIT     = (PROD_W'(1) << (WORD_BITS - 1)) - PROD_W'(1);
  localparam logic [PROD_W-1:0] LIMIT_NEG = LIMIT + PROD_W'(1);

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_MUL  = 2'd1,
    MODE_DIV  = 2'd2,
    MODE_NORM = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    logic [PROD_W-1:0] sum;
    logic              ge;
    logic              eq;
  } alu_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_X,
    S_MUL_D,
    S_MUL_Y,
    S_MUL_W,
    S_SUM,
    S_GCD,
    S_DIV,
    S_FIN,
    S_PUSH
  } state_e;

endpackage

[rtl/rau_if.sv]
// valid/ready channel interfaces for operand and result items
interface rau_in_if;
  import rau_pkg::*;

  logic                       valid;
  logic                       ready;
  mode_e                      mode;
  logic signed [FIELD_W-1:0]  a_num;
  logic signed [FIELD_W-1:0]  a_den;
  logic signed [FIELD_W-1:0]  b_num;
  logic signed [FIELD_W-1:0]  b_den;

  modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  import rau_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [FIELD_W-1:0]  result_num;
  logic [RES_DEN_W-1:0]       result_den;
  status_e                    status;

  modport source (output valid, result_num, result_den, status, input ready);
  modport sink   (input valid, result_num, result_den, status, output ready);
endinterface

[rtl/rau_mul.sv]
// registered magnitude multiplier, one product per cycle
module rau_mul (
  input  logic                        clk_i,
  input  logic [rau_pkg::MAG_W-1:0]   a_i,
  input  logic [rau_pkg::MAG_W-1:0]   b_i,
  output logic [rau_pkg::PROD_W-1:0]  p_o
);
  import rau_pkg::*;

  always_ff @(posedge clk_i) begin
    p_o <= PROD_W'(a_i) * PROD_W'(b_i);
  end

endmodule

[rtl/rau_sub.sv]
// shared double-width add/subtract and compare unit
module rau_sub (
  input  logic [rau_pkg::PROD_W-1:0]  a_i,
  input  logic [rau_pkg::PROD_W-1:0]  b_i,
  input  rau_pkg::alu_op_e            op_i,
  output rau_pkg::alu_res_t           res_o
);
  import rau_pkg::*;

  logic [PROD_W:0]   full;
  logic [PROD_W-1:0] b_eff;
  logic              is_sub;

  always_comb begin
    is_sub = (op_i == ALU_SUB);
    b_eff  = is_sub ? ~b_i : b_i;
    full   = {1'b0, a_i} + {1'b0, b_eff} + {{PROD_W{1'b0}}, is_sub};
    // carry out of a subtract means no borrow, a >= b
    res_o.sum = full[PROD_W-1:0];
    res_o.ge  = full[PROD_W];
    res_o.eq  = (a_i == b_i);
  end

endmodule

[rtl/rational_arithmetic_unit_core.sv]
// top level of the rational arithmetic unit: sequencer and datapath registers
//
//   channel  dir  handshake           payload
//   in_i     in   valid/ready (sink)  mode, a_num, a_den, b_num, b_den
//   out_o    out  valid/ready (src)   result_num, result_den, status
//
// an item passes through four multiplier states, one or two sum states, the
// binary gcd steps and two 64-bit restoring divisions on the shared 64-bit
// subtractor, a finish state and a push state. a zero denominator or divisor
// goes from the first multiplier state to push, a zero numerator from the sum
// state. in_i.ready is high only while the sequencer is idle. the output
// register holds a result until taken, so a new item is accepted while the
// last result still waits. reset clears the sequencer and out valid.
`include "rational_arithmetic_unit_core_macros.svh"

module rational_arithmetic_unit_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  rau_in_if.sink    in_i,
  rau_out_if.source out_o
);
  import rau_pkg::*;

  // sequencer
  state_e state_q, state_d;

  // captured operands in sign-magnitude form
  mode_e             mode_q;
  logic [MAG_W-1:0]  an_q, ad_q, bn_q, bd_q;
  logic              an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;

  // cross products and their signs: x and y are the numerator terms
  logic [PROD_W-1:0] x_q, y_q, d_q, n_q;
  logic              xn_q, yn_q, dn_q, nn_q;

  // gcd and division working registers
  logic [PROD_W-1:0] u_q, v_q, g_q, q_q, rem_q, rn_q;
  logic [CNT_W-1:0]  k_q, cnt_q;
  logic              phase_q;

  // staged result waiting for the output register
  logic [FIELD_W-1:0]   st_num_q;
  logic [RES_DEN_W-1:0] st_den_q;
  status_e              st_stat_q;

  // output register
  logic                 ov_q;
  logic [FIELD_W-1:0]   out_num_q;
  logic [RES_DEN_W-1:0] out_den_q;
  status_e              out_stat_q;

  // combinational
  logic [MAG_W-1:0]  mul_a, mul_b, mul_x_b, mul_d_b, mul_y_a;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] alu_a, alu_b;
  alu_op_e           alu_op;
  alu_res_t          alu_res;
  logic              sx, sd, sy;
  logic              op_err;
  logic              sum_done;
  logic [PROD_W-1:0] rem_sh, q_nx;
  logic              cnt_last;
  logic              fin_neg, fin_ovf;
  logic [FIELD_W-1:0] fin_num;
  logic              out_free;
  logic              in_acc;

  function automatic logic [MAG_W-1:0] sm_mag(input logic [FIELD_W-1:0] v);
    sm_mag = v[FIELD_W-1] ? (MAG_W'(0) - MAG_W'(v)) : MAG_W'(v);
  endfunction

  rau_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  rau_sub u_sub (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .op_i  (alu_op),
    .res_o (alu_res)
  );

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !ov_q || out_o.ready;

  // factor and sign selection per operation; normalize multiplies by one
  always_comb begin
    sx      = an_neg_q ^ bd_neg_q;
    sd      = ad_neg_q ^ bd_neg_q;
    sy      = bn_neg_q ^ ad_neg_q;
    mul_x_b = bd_q;
    mul_d_b = bd_q;
    mul_y_a = bn_q;
    case (mode_q)
      MODE_MUL: begin
        sx      = an_neg_q ^ bn_neg_q;
        sy      = 1'b0;
        mul_x_b = bn_q;
        mul_y_a = '0;
      end
      MODE_DIV: begin
        sd      = ad_neg_q ^ bn_neg_q;
        sy      = 1'b0;
        mul_d_b = bn_q;
        mul_y_a = '0;
      end
      MODE_NORM: begin
        sx      = an_neg_q;
        sd      = ad_neg_q;
        sy      = 1'b0;
        mul_x_b = MAG_W'(1);
        mul_d_b = MAG_W'(1);
        mul_y_a = '0;
      end
      default: begin
        // add keeps the defaults above
      end
    endcase
  end

  // zero denominator, or zero divisor in divide mode
  assign op_err = (ad_q == '0) ||
                  ((mode_q != MODE_NORM) && (bd_q == '0)) ||
                  ((mode_q == MODE_DIV) && (bn_q == '0));

  assign sum_done = (xn_q == yn_q) || alu_res.ge;

  // restoring division step: shift dividend bit into the remainder
  assign rem_sh   = {rem_q[PROD_W-2:0], q_q[PROD_W-1]};
  assign q_nx     = {q_q[PROD_W-2:0], alu_res.ge};
  assign cnt_last = (cnt_q == CNT_W'(PROD_W - 1));

  // final range check; q_q holds the reduced denominator here
  assign fin_neg = nn_q ^ dn_q;
  assign fin_ovf = (q_q > LIMIT) || (!fin_neg && (rn_q > LIMIT)) ||
                   (fin_neg && (rn_q > LIMIT_NEG));
  assign fin_num = fin_neg ? (FIELD_W'(0) - rn_q[FIELD_W-1:0]) : rn_q[FIELD_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_i.valid) state_d = S_MUL_X;
      S_MUL_X: state_d = op_err ? S_PUSH : S_MUL_D;
      S_MUL_D: state_d = S_MUL_Y;
      S_MUL_Y: state_d = S_MUL_W;
      S_MUL_W: state_d = S_SUM;
      S_SUM: begin
        if (sum_done) state_d = (alu_res.sum == '0) ? S_PUSH : S_GCD;
      end
      S_GCD:   if (alu_res.eq) state_d = S_DIV;
      S_DIV:   if (cnt_last && phase_q) state_d = S_FIN;
      S_FIN:   state_d = S_PUSH;
      S_PUSH:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs: handshake and operand steering of the shared units
  always_comb begin
    in_i.ready = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    alu_a      = x_q;
    alu_b      = y_q;
    alu_op     = ALU_ADD;
    case (state_q)
      S_IDLE:  in_i.ready = 1'b1;
      S_MUL_X: begin
        mul_a = an_q;
        mul_b = mul_x_b;
      end
      S_MUL_D: begin
        mul_a = ad_q;
        mul_b = mul_d_b;
      end
      S_MUL_Y: begin
        mul_a = mul_y_a;
        mul_b = ad_q;
      end
      S_SUM:   alu_op = (xn_q == yn_q) ? ALU_ADD : ALU_SUB;
      S_GCD: begin
        alu_a  = u_q;
        alu_b  = v_q;
        alu_op = ALU_SUB;
      end
      S_DIV: begin
        alu_a  = rem_sh;
        alu_b  = g_q;
        alu_op = ALU_SUB;
      end
      default: begin
        // units idle
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      phase_q <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_GCD: begin
          if (alu_res.eq) begin
            cnt_q   <= '0;
            phase_q <= 1'b0;
          end else if (!u_q[0] && !v_q[0]) begin
            k_q <= k_q + 1'b1;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
          if (cnt_last) phase_q <= 1'b1;
        end
        S_SUM:   k_q <= '0;
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          mode_q   <= in_i.mode;
          an_q     <= sm_mag(in_i.a_num);
          ad_q     <= sm_mag(in_i.a_den);
          bn_q     <= sm_mag(in_i.b_num);
          bd_q     <= sm_mag(in_i.b_den);
          an_neg_q <= in_i.a_num[FIELD_W-1];
          ad_neg_q <= in_i.a_den[FIELD_W-1];
          bn_neg_q <= in_i.b_num[FIELD_W-1];
          bd_neg_q <= in_i.b_den[FIELD_W-1];
        end
      end
      S_MUL_X: begin
        st_num_q  <= '0;
        st_den_q  <= '0;
        st_stat_q <= ST_ZERO;
      end
      S_MUL_D: begin
        x_q  <= prod;
        xn_q <= sx;
      end
      S_MUL_Y: begin
        d_q  <= prod;
        dn_q <= sd;
      end
      S_MUL_W: begin
        y_q  <= prod;
        yn_q <= sy;
      end
      S_SUM: begin
        if (sum_done) begin
          n_q       <= alu_res.sum;
          nn_q      <= xn_q;
          u_q       <= alu_res.sum;
          v_q       <= d_q;
          // zero numerator reduces to 0/1
          st_num_q  <= '0;
          st_den_q  <= RES_DEN_W'(1);
          st_stat_q <= ST_OK;
        end else begin
          // opposite signs with the smaller term first: swap and retry
          x_q  <= y_q;
          y_q  <= x_q;
          xn_q <= yn_q;
          yn_q <= xn_q;
        end
      end
      S_GCD: begin
        // binary gcd step, common factors of two counted in k
        if (alu_res.eq) begin
          g_q   <= u_q << k_q;
          q_q   <= n_q;
          rem_q <= '0;
        end else if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (alu_res.ge) begin
          u_q <= alu_res.sum >> 1;
        end else begin
          u_q <= v_q;
          v_q <= u_q;
        end
      end
      S_DIV: begin
        if (cnt_last && !phase_q) begin
          // numerator quotient done, start on the denominator
          rn_q  <= q_nx;
          q_q   <= d_q;
          rem_q <= '0;
        end else begin
          rem_q <= alu_res.ge ? alu_res.sum : rem_sh;
          q_q   <= q_nx;
        end
      end
      S_FIN: begin
        if (fin_ovf) begin
          st_num_q  <= '0;
          st_den_q  <= '0;
          st_stat_q <= ST_OVF;
        end else begin
          st_num_q  <= fin_num;
          st_den_q  <= q_q[RES_DEN_W-1:0];
          st_stat_q <= ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // output register, loaded from the staged result when free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if ((state_q == S_PUSH) && out_free) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_PUSH) && out_free) begin
      out_num_q  <= st_num_q;
      out_den_q  <= st_den_q;
      out_stat_q <= st_stat_q;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.result_num = $signed(out_num_q);
  assign out_o.result_den = out_den_q;
  assign out_o.status     = out_stat_q;

  `RAU_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_acc, state_q == S_MUL_X)
  `RAU_ASSERT_IMPL(a_gcd_nonzero, clk_i, rst_ni, state_q == S_GCD, (u_q != '0) && (v_q != '0))
  `RAU_ASSERT_IMPL(a_div_nonzero, clk_i, rst_ni, state_q == S_DIV, g_q != '0)
  `RAU_ASSERT_IMPL(a_ok_den, clk_i, rst_ni, ov_q && (out_stat_q == ST_OK), out_den_q != '0)
  `RAU_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, ov_q && (out_stat_q != ST_OK), (out_num_q == '0) && (out_den_q == '0))

endmodule
